// ----- src/tdma_slot_allocator_top_defines.svh -----
// ---------------------------------------------------------------------------
// tdma slot allocator assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, off in reset
// ---------------------------------------------------------------------------
`ifndef TDMA_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define TDMA_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define TSA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define TSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/tsa_pkg.sv -----
// ---------------------------------------------------------------------------
// tdma slot allocator package
// field widths, operation and status codes, sequencer states
// ---------------------------------------------------------------------------
package tsa_pkg;

  // table sizes, fixed by the field widths below
  localparam int MAX_SLOTS = 32;
  localparam int MAX_NODES = 16;

  localparam int FuncW   = 3;
  localparam int NodeW   = 4;
  localparam int AmountW = 16;
  localparam int SlotW   = 5;
  localparam int StatusW = 2;
  localparam int HeldW   = 6;
  localparam int CfgW    = 6;
  localparam int InDataW  = 32;
  localparam int OutDataW = 16;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [FuncW-1:0] FuncJoin    = 3'd0;
  localparam logic [FuncW-1:0] FuncClaim   = 3'd1;
  localparam logic [FuncW-1:0] FuncRequest = 3'd2;
  localparam logic [FuncW-1:0] FuncRelease = 3'd3;
  localparam logic [FuncW-1:0] FuncRead    = 3'd4;

  localparam logic [StatusW-1:0] StatOk       = 2'd0;
  localparam logic [StatusW-1:0] StatBadNode  = 2'd1;
  localparam logic [StatusW-1:0] StatRange    = 2'd2;
  localparam logic [StatusW-1:0] StatNoSlot   = 2'd3;

  localparam logic RegSlotsInUse = 1'b0;
  localparam logic [CfgW-1:0] SlotsInUseRst = 6'd32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_POST,
    ST_CLAIM_WR,
    ST_ALC_RD,
    ST_ALC_EV,
    ST_CHK_W,
    ST_CHK_WD,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_RB_CLR,
    ST_RB_W,
    ST_RB_WD,
    ST_FIN_RD,
    ST_FIN_EV,
    ST_DONE
  } tsa_state_e;

endpackage

// ----- src/tsa_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// tdma slot allocator configuration registers
// apb write/read of slots_in_use and clamping to the usable cycle length
// ---------------------------------------------------------------------------
module tsa_cfg_regs import tsa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrW-1:0]           paddr,
  input  logic [ApbDataW-1:0]           pwdata,
  output logic [ApbDataW-1:0]           prdata,
  output logic                          pready,
  output logic [$clog2(MAX_SLOTS+1)-1:0] n_o
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [CfgW-1:0] slots_q, slots_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegSlotsInUse);

  always_comb begin
    slots_d = slots_q;
    if (wr_en) begin
      slots_d = pwdata[CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SlotsInUseRst;
    end else begin
      slots_q <= slots_d;
    end
  end

  assign prdata = (paddr[2] == RegSlotsInUse) ? {{(ApbDataW-CfgW){1'b0}}, slots_q} : '0;

  // cycle length clamped to 1..MAX_SLOTS
  always_comb begin
    if (slots_q == '0) begin
      n_o = CW'(1);
    end else if (32'(slots_q) > MAX_SLOTS) begin
      n_o = CW'(MAX_SLOTS);
    end else begin
      n_o = CW'(slots_q);
    end
  end

endmodule

// ----- src/tdma_slot_allocator_top.sv -----
// ---------------------------------------------------------------------------
// tdma slot allocator
// owner table, freed marks and wanted counts for one tdma cycle
// ---------------------------------------------------------------------------
// One operation at a time. Each accepted beat runs a sequencer over two
// single-port memories with registered reads: the slot table (owner and
// freed mark per slot) and the wanted-count table per node. Every slot visit
// is a read, then a modify/write. A valid operation scans the n =
// slots_in_use slots once; a claim adds a write, a request that fits in spare
// slots adds an allocation pass, and a release checks each node with a
// nonzero wanted count up to the first unmet one. A table rebuild clears the
// n slots, then deals slots to the nodes round-robin. The result sits in an
// output register, so the next beat is taken while it waits. Reset clears
// the tables through per-entry valid bits, with no clearing pass.
`include "tdma_slot_allocator_top_defines.svh"

module tdma_slot_allocator_top import tsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // in beat: func[2:0] node[6:3] amount[22:7] slot[27:23], zero fill
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  // out beat: status[1:0] owner[5:2] freed[6] held_count[12:7] rebuilt[13]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW  = NodeW + 1;  // slot entry: freed mark above owner

  // cycle length from the config block
  logic [CW-1:0] n;

  tsa_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .n_o    (n)
  );

  // input fields
  logic [FuncW-1:0]   in_func;
  logic [NodeW-1:0]   in_node;
  logic [AmountW-1:0] in_amount;
  logic [SlotW-1:0]   in_slot;
  logic               in_node_ok;
  logic               s_acc;

  assign in_func    = s_axis_tdata[2:0];
  assign in_node    = s_axis_tdata[6:3];
  assign in_amount  = s_axis_tdata[22:7];
  assign in_slot    = s_axis_tdata[27:23];
  assign in_node_ok = (in_node != '0) && (32'(in_node) < MAX_NODES);
  assign s_acc      = s_axis_tvalid && s_axis_tready;

  // sequencer and working registers
  tsa_state_e state_q, state_d;

  logic [FuncW-1:0]   func_q, func_d;
  logic [NodeW-1:0]   node_q, node_d;
  logic [AmountW-1:0] amount_q, amount_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               node_ok_q, node_ok_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      held_q, held_d;
  logic [CW-1:0]      cnt_q, cnt_d;      // spare count, later owner count
  logic [SW-1:0]      fu_q, fu_d;        // first unowned slot
  logic               fu_found_q, fu_found_d;
  logic               fu_freed_q, fu_freed_d;
  logic [NodeW-1:0]   old_owner_q, old_owner_d;
  logic               old_freed_q, old_freed_d;
  logic [CW-1:0]      need_q, need_d;
  logic [NIW-1:0]     j_q, j_d;          // node walker for check and rebuild
  logic [CW-1:0]      wantj_q, wantj_d;
  logic [CW-1:0]      round_q, round_d;
  logic [CW-1:0]      filled_q, filled_d;
  logic               any_q, any_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               rebuilt_q, rebuilt_d;
  logic [SW-1:0]      addr_q, addr_d;
  logic               addr_ok_q, addr_ok_d;
  logic [NodeW-1:0]   res_owner_q, res_owner_d;
  logic               res_freed_q, res_freed_d;

  // slot table memory
  logic [EW-1:0]        slot_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_vld_q;
  logic                 s_re, s_we;
  logic [SW-1:0]        s_ra, s_wa;
  logic [EW-1:0]        s_wd;
  logic [EW-1:0]        s_rd_q;
  logic                 s_rv_q;

  // wanted-count memory
  logic [CW-1:0]        want_mem [MAX_NODES];
  logic [MAX_NODES-1:0] want_vld_q;
  logic                 w_re, w_we;
  logic [NIW-1:0]       w_ra, w_wa;
  logic [CW-1:0]        w_wd;
  logic [CW-1:0]        w_rd_q;
  logic                 w_rv_q;

  // output register
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic                out_free;

  // read data, never-written entries read as reset value
  logic [NodeW-1:0] e_owner;
  logic             e_freed;
  logic [CW-1:0]    e_want;
  logic             e_spare;
  logic [CW-1:0]    idx_inc;
  logic             scan_end;
  logic             slot_in;
  logic             j_last;
  logic [CW-1:0]    want_clamp;
  logic             give;
  logic [CW-1:0]    filled_inc;
  logic [CW-1:0]    chk_cnt;

  assign e_owner    = s_rv_q ? s_rd_q[NodeW-1:0] : '0;
  assign e_freed    = s_rv_q ? s_rd_q[NodeW] : 1'b0;
  assign e_want     = w_rv_q ? w_rd_q : '0;
  assign e_spare    = e_freed || (e_owner == '0);
  assign idx_inc    = idx_q + CW'(1);
  assign scan_end   = (idx_inc == n);
  assign slot_in    = 32'(slot_q) < 32'(n);
  assign j_last     = (j_q == NIW'(MAX_NODES - 1));
  assign want_clamp = (32'(amount_q) > 32'(n)) ? n : CW'(amount_q);
  assign give       = e_want > round_q;
  assign filled_inc = filled_q + CW'(1);
  assign chk_cnt    = cnt_q + CW'(e_owner == NodeW'(j_q));
  assign out_free   = !m_tvalid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (in_func > FuncRead) begin
            state_d = ST_DONE;
          end else if (in_func != FuncRead && !in_node_ok) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: state_d = scan_end ? ST_POST : ST_SCAN_RD;
      ST_POST: begin
        unique case (func_q)
          FuncClaim:   state_d = slot_in ? ST_CLAIM_WR : ST_FIN_RD;
          FuncRequest: begin
            if (want_clamp > held_q) begin
              state_d = ((want_clamp - held_q) > cnt_q) ? ST_RB_CLR : ST_ALC_RD;
            end else begin
              state_d = ST_FIN_RD;
            end
          end
          FuncRelease: state_d = ST_CHK_W;
          default:     state_d = ST_FIN_RD;
        endcase
      end
      ST_CLAIM_WR: state_d = ST_FIN_RD;
      ST_ALC_RD:   state_d = ST_ALC_EV;
      ST_ALC_EV: begin
        if (scan_end || (e_spare && need_q == CW'(1))) begin
          state_d = ST_FIN_RD;
        end else begin
          state_d = ST_ALC_RD;
        end
      end
      ST_CHK_W: state_d = ST_CHK_WD;
      ST_CHK_WD: begin
        if (e_want == '0) begin
          state_d = j_last ? ST_FIN_RD : ST_CHK_W;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_CHK_RD: state_d = ST_CHK_EV;
      ST_CHK_EV: begin
        if (scan_end) begin
          if (wantj_q > chk_cnt) begin
            state_d = ST_RB_CLR;
          end else begin
            state_d = j_last ? ST_FIN_RD : ST_CHK_W;
          end
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_RB_CLR: state_d = scan_end ? ST_RB_W : ST_RB_CLR;
      ST_RB_W:   state_d = ST_RB_WD;
      ST_RB_WD: begin
        if (give && filled_inc == n) begin
          state_d = ST_FIN_RD;
        end else if (j_last) begin
          state_d = (any_q || give) ? ST_RB_W : ST_FIN_RD;
        end else begin
          state_d = ST_RB_W;
        end
      end
      ST_FIN_RD: state_d = ST_FIN_EV;
      ST_FIN_EV: state_d = ST_DONE;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    func_d      = func_q;
    node_d      = node_q;
    amount_d    = amount_q;
    slot_d      = slot_q;
    node_ok_d   = node_ok_q;
    idx_d       = idx_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    fu_d        = fu_q;
    fu_found_d  = fu_found_q;
    fu_freed_d  = fu_freed_q;
    old_owner_d = old_owner_q;
    old_freed_d = old_freed_q;
    need_d      = need_q;
    j_d         = j_q;
    wantj_d     = wantj_q;
    round_d     = round_q;
    filled_d    = filled_q;
    any_d       = any_q;
    status_d    = status_q;
    rebuilt_d   = rebuilt_q;
    addr_d      = addr_q;
    addr_ok_d   = addr_ok_q;
    res_owner_d = res_owner_q;
    res_freed_d = res_freed_q;
    s_re = 1'b0;
    s_ra = idx_q[SW-1:0];
    s_we = 1'b0;
    s_wa = idx_q[SW-1:0];
    s_wd = '0;
    w_re = 1'b0;
    w_ra = j_q;
    w_we = 1'b0;
    w_wa = NIW'(node_q);
    w_wd = want_clamp;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          func_d      = in_func;
          node_d      = in_node;
          amount_d    = in_amount;
          slot_d      = in_slot;
          node_ok_d   = in_node_ok;
          idx_d       = '0;
          held_d      = '0;
          cnt_d       = '0;
          fu_found_d  = 1'b0;
          old_owner_d = '0;
          old_freed_d = 1'b0;
          rebuilt_d   = 1'b0;
          addr_ok_d   = 1'b0;
          res_owner_d = '0;
          res_freed_d = 1'b0;
          status_d    = StatOk;
          if (in_func <= FuncRelease && !in_node_ok) begin
            status_d = StatBadNode;
          end
        end
      end
      ST_SCAN_RD: s_re = 1'b1;
      ST_SCAN_EV: begin
        if (node_ok_q && e_owner == node_q) begin
          held_d = held_q + CW'(1);
        end
        if (e_spare) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (!fu_found_q && e_owner == '0) begin
          fu_d       = idx_q[SW-1:0];
          fu_found_d = 1'b1;
          fu_freed_d = e_freed;
        end
        if (32'(idx_q) == 32'(slot_q)) begin
          old_owner_d = e_owner;
          old_freed_d = e_freed;
        end
        // release marks the node's slots freed on the way
        if (func_q == FuncRelease && e_owner == node_q) begin
          s_we = 1'b1;
          s_wd = {1'b1, e_owner};
        end
        idx_d = idx_inc;
      end
      ST_POST: begin
        case (func_q)
          FuncJoin: begin
            if (fu_found_q) begin
              s_we      = 1'b1;
              s_wa      = fu_q;
              s_wd      = {fu_freed_q, node_q};
              addr_d    = fu_q;
              addr_ok_d = 1'b1;
            end else begin
              status_d = StatNoSlot;
            end
          end
          FuncClaim: begin
            if (!slot_in) begin
              status_d = StatRange;
            end else begin
              // displaced owner moves to the first unowned slot
              if (old_owner_q != '0 && old_owner_q != node_q) begin
                if (fu_found_q) begin
                  s_we = 1'b1;
                  s_wa = fu_q;
                  s_wd = {fu_freed_q, old_owner_q};
                end else begin
                  status_d = StatNoSlot;
                end
              end
              addr_d    = SW'(slot_q);
              addr_ok_d = 1'b1;
            end
          end
          FuncRequest: begin
            w_we      = 1'b1;
            addr_d    = SW'(slot_q);
            addr_ok_d = slot_in;
            idx_d     = '0;
            if (want_clamp > held_q) begin
              rebuilt_d = 1'b1;
              need_d    = want_clamp - held_q;
              j_d       = NIW'(1);
              round_d   = '0;
              filled_d  = '0;
              any_d     = 1'b0;
            end
          end
          FuncRelease: begin
            addr_d    = SW'(slot_q);
            addr_ok_d = slot_in;
            j_d       = NIW'(1);
          end
          default: begin
            if (slot_in) begin
              addr_d    = SW'(slot_q);
              addr_ok_d = 1'b1;
            end else begin
              status_d = StatRange;
            end
          end
        endcase
      end
      ST_CLAIM_WR: begin
        s_we = 1'b1;
        s_wa = SW'(slot_q);
        s_wd = {old_freed_q, node_q};
      end
      ST_ALC_RD: s_re = 1'b1;
      ST_ALC_EV: begin
        if (e_spare) begin
          s_we   = 1'b1;
          s_wd   = {1'b0, node_q};
          need_d = need_q - CW'(1);
        end
        idx_d = idx_inc;
      end
      ST_CHK_W: w_re = 1'b1;
      ST_CHK_WD: begin
        wantj_d = e_want;
        idx_d   = '0;
        cnt_d   = '0;
        if (e_want == '0 && !j_last) begin
          j_d = j_q + NIW'(1);
        end
      end
      ST_CHK_RD: s_re = 1'b1;
      ST_CHK_EV: begin
        cnt_d = chk_cnt;
        idx_d = idx_inc;
        if (scan_end) begin
          if (wantj_q > chk_cnt) begin
            // unmet request: rebuild from a clean table
            rebuilt_d = 1'b1;
            idx_d     = '0;
            j_d       = NIW'(1);
            round_d   = '0;
            filled_d  = '0;
            any_d     = 1'b0;
          end else if (!j_last) begin
            j_d = j_q + NIW'(1);
          end
        end
      end
      ST_RB_CLR: begin
        s_we  = 1'b1;
        s_wd  = '0;
        idx_d = idx_inc;
      end
      ST_RB_W: w_re = 1'b1;
      ST_RB_WD: begin
        if (give) begin
          s_we     = 1'b1;
          s_wa     = filled_q[SW-1:0];
          s_wd     = {1'b0, NodeW'(j_q)};
          filled_d = filled_inc;
          any_d    = 1'b1;
        end
        if (j_last) begin
          j_d     = NIW'(1);
          round_d = round_q + CW'(1);
          any_d   = 1'b0;
        end else begin
          j_d = j_q + NIW'(1);
        end
      end
      ST_FIN_RD: begin
        s_re = addr_ok_q;
        s_ra = addr_q;
      end
      ST_FIN_EV: begin
        res_owner_d = addr_ok_q ? e_owner : '0;
        res_freed_d = addr_ok_q ? e_freed : 1'b0;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    node_q      <= node_d;
    amount_q    <= amount_d;
    slot_q      <= slot_d;
    node_ok_q   <= node_ok_d;
    idx_q       <= idx_d;
    held_q      <= held_d;
    cnt_q       <= cnt_d;
    fu_q        <= fu_d;
    fu_found_q  <= fu_found_d;
    fu_freed_q  <= fu_freed_d;
    old_owner_q <= old_owner_d;
    old_freed_q <= old_freed_d;
    need_q      <= need_d;
    j_q         <= j_d;
    wantj_q     <= wantj_d;
    round_q     <= round_d;
    filled_q    <= filled_d;
    any_q       <= any_d;
    status_q    <= status_d;
    rebuilt_q   <= rebuilt_d;
    addr_q      <= addr_d;
    addr_ok_q   <= addr_ok_d;
    res_owner_q <= res_owner_d;
    res_freed_q <= res_freed_d;
  end

  // slot table: data array plus reset-cleared valid bits
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      slot_mem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd_q <= slot_mem[s_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      s_rv_q     <= 1'b0;
    end else begin
      if (s_we) begin
        slot_vld_q[s_wa] <= 1'b1;
      end
      if (s_re) begin
        s_rv_q <= slot_vld_q[s_ra];
      end
    end
  end

  // wanted-count table
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      want_mem[w_wa] <= w_wd;
    end
    if (w_re) begin
      w_rd_q <= want_mem[w_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_vld_q <= '0;
      w_rv_q     <= 1'b0;
    end else begin
      if (w_we) begin
        want_vld_q[w_wa] <= 1'b1;
      end
      if (w_re) begin
        w_rv_q <= want_vld_q[w_ra];
      end
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_tdata_q <= {2'b00, rebuilt_q, HeldW'(held_q), res_freed_q, res_owner_q, status_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `TSA_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state_q != ST_IDLE, "accepted beat did not start the sequencer")
  `TSA_ASSERT_NOW(a_slot_no_rw_clash, s_we && s_re, s_wa != s_ra, "slot table read and write hit one entry")
  `TSA_ASSERT_NOW(a_walk_in_range, state_q == ST_SCAN_RD || state_q == ST_ALC_RD || state_q == ST_CHK_RD || state_q == ST_RB_CLR, idx_q < n, "slot walker beyond cycle length")
  `TSA_ASSERT_NEXT(a_done_waits, state_q == ST_DONE && m_tvalid_q && !m_axis_tready, state_q == ST_DONE, "result dropped while output register full")

endmodule
